>>> src/art_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// art_pkg
// Shared codes, the table entry layout and the controller/datapath links.
// ----------------------------------------------------------------------------
package art_pkg;

  // input command codes
  localparam logic [1:0] CMD_OUTGOING = 2'd0;
  localparam logic [1:0] CMD_INCOMING = 2'd1;
  localparam logic [1:0] CMD_SCAN     = 2'd2;

  // result action codes
  localparam logic [1:0] ACT_SEND_ACK = 2'd0;
  localparam logic [1:0] ACT_RESEND   = 2'd1;
  localparam logic [1:0] ACT_DROP     = 2'd2;

  localparam logic [15:0] TIMEOUT_RESET = 16'd3500;

  typedef struct packed {
    logic [15:0] seq;
    logic [7:0]  handle;
    logic [31:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller -> datapath
  typedef struct packed {
    logic       capture;
    logic       idx_clear;
    logic       idx_inc;
    logic       rd_next;
    logic       wr_append;
    logic       wr_shift;
    logic       wr_time;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       hold_load;
    logic       hold_clear;
    logic       push_hold;
    logic       push_last;
    logic       push_direct;
    logic [1:0] direct_action;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       is_ack;
    logic       full;
    logic       idx_at_end;
    logic       idx_last;
    logic       seq_match;
    logic       due;
    logic       hold_valid;
    logic       out_free;
  } ctrl_status_t;

endpackage

>>> src/art_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// art_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module art_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/art_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// art_datapath
// Request registers, table RAM, walk index, entry count, hold and output stage.
// ----------------------------------------------------------------------------
module art_datapath #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  art_pkg::ctrl_cmd_t   cmd,
  output art_pkg::ctrl_status_t status,
  input  logic [2:0]           s_tuser,
  input  logic [55:0]          s_tdata,
  input  logic                 cfg_valid,
  input  logic [15:0]          cfg_data,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,
  output logic [1:0]           m_tuser,
  output logic                 m_tlast
);
  import art_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [1:0]  req_cmd;
  logic        req_ack;
  logic [15:0] req_seq;
  logic [7:0]  req_ref;
  logic [31:0] req_now;
  logic [15:0] timeout;

  logic [CW-1:0] idx;
  logic [CW-1:0] idx_p1;
  logic [CW-1:0] count;

  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  logic [IW-1:0] rd_addr;
  entry_t        rd_data;
  logic [31:0]   age;

  logic        hold_valid;
  logic [15:0] hold_seq;
  logic [7:0]  hold_ref;

  logic        out_valid;
  logic [1:0]  out_action;
  logic [15:0] out_seq;
  logic [7:0]  out_ref;
  logic        out_last;
  logic        out_free;

  assign idx_p1   = idx + CW'(1);
  assign out_free = !out_valid || m_tready;
  assign age      = req_now - rd_data.stamp;

  always_comb begin
    rd_addr = cmd.rd_next ? idx_p1[IW-1:0] : idx[IW-1:0];
    wr_en   = cmd.wr_append || cmd.wr_shift || cmd.wr_time;
    wr_addr = idx[IW-1:0];
    wr_data = rd_data;
    if (cmd.wr_append) begin
      wr_addr = count[IW-1:0];
      wr_data = '{seq: req_seq, handle: req_ref, stamp: req_now};
    end else if (cmd.wr_time) begin
      wr_data.stamp = req_now;
    end
  end

  art_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // capture the request and keep the timeout
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_cmd <= s_tuser[1:0];
      req_ack <= s_tuser[2];
      req_seq <= s_tdata[15:0];
      req_ref <= s_tdata[23:16];
      req_now <= s_tdata[55:24];
    end
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      timeout <= cfg_data;
    end
  end

  // walk index and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      count <= '0;
    end else begin
      if (cmd.idx_clear) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx_p1;
      end
      if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
    end
  end

  // hold the latest due entry until the next one shows whether it is last
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (cmd.hold_load) begin
      hold_valid <= 1'b1;
    end else if (cmd.hold_clear) begin
      hold_valid <= 1'b0;
    end
    if (cmd.hold_load) begin
      hold_seq <= rd_data.seq;
      hold_ref <= rd_data.handle;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push_hold || cmd.push_direct) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (cmd.push_hold) begin
      out_action <= ACT_RESEND;
      out_seq    <= hold_seq;
      out_ref    <= hold_ref;
      out_last   <= cmd.push_last;
    end else if (cmd.push_direct) begin
      out_action <= cmd.direct_action;
      out_seq    <= req_seq;
      out_ref    <= req_ref;
      out_last   <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_ref, out_seq};
  assign m_tuser  = out_action;
  assign m_tlast  = out_last;

  always_comb begin
    status.cmd        = req_cmd;
    status.is_ack     = req_ack;
    status.full       = (count == CW'(TABLE_DEPTH));
    status.idx_at_end = (idx == count);
    status.idx_last   = (idx_p1 == count);
    status.seq_match  = (rd_data.seq == req_seq);
    status.due        = (age > {16'd0, timeout});
    status.hold_valid = hold_valid;
    status.out_free   = out_free;
  end

endmodule

>>> src/art_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// art_ctrl
// Sequencer for append, ack search and close-up, and the resend scan.
// ----------------------------------------------------------------------------
module art_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  art_pkg::ctrl_status_t status,
  output art_pkg::ctrl_cmd_t    cmd
);
  import art_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_EMIT,
    ST_ACK_RD,
    ST_ACK_EV,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_SCAN_FIN
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] emit_action;
  logic [1:0] emit_action_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd              = '0;
    state_next       = state;
    emit_action_next = emit_action;
    cmd.direct_action = emit_action;
    case (state)
      ST_IDLE: begin
        cmd.capture = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_next = ST_IDLE;
        case (status.cmd)
          CMD_OUTGOING: begin
            if (!status.is_ack) begin
              if (status.full) begin
                emit_action_next = ACT_DROP;
                state_next       = ST_EMIT;
              end else begin
                cmd.wr_append = 1'b1;
                cmd.cnt_inc   = 1'b1;
              end
            end
          end
          CMD_INCOMING: begin
            if (status.is_ack) begin
              cmd.idx_clear = 1'b1;
              state_next    = ST_ACK_RD;
            end else begin
              emit_action_next = ACT_SEND_ACK;
              state_next       = ST_EMIT;
            end
          end
          CMD_SCAN: begin
            cmd.idx_clear  = 1'b1;
            cmd.hold_clear = 1'b1;
            state_next     = ST_SCAN_RD;
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.push_direct = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      ST_ACK_RD: begin
        state_next = status.idx_at_end ? ST_IDLE : ST_ACK_EV;
      end
      ST_ACK_EV: begin
        if (status.seq_match) begin
          state_next = ST_SHIFT_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = ST_ACK_RD;
        end
      end
      ST_SHIFT_RD: begin
        if (status.idx_last) begin
          cmd.cnt_dec = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          cmd.rd_next = 1'b1;
          state_next  = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        cmd.rd_next  = 1'b1;
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_next   = ST_SHIFT_RD;
      end
      ST_SCAN_RD: begin
        if (status.idx_at_end) begin
          state_next = status.hold_valid ? ST_SCAN_FIN : ST_IDLE;
        end else begin
          state_next = ST_SCAN_EV;
        end
      end
      ST_SCAN_EV: begin
        if (!status.due) begin
          cmd.idx_inc = 1'b1;
          state_next  = ST_SCAN_RD;
        end else if (!status.hold_valid || status.out_free) begin
          cmd.wr_time   = 1'b1;
          cmd.hold_load = 1'b1;
          cmd.push_hold = status.hold_valid;
          cmd.idx_inc   = 1'b1;
          state_next    = ST_SCAN_RD;
        end
      end
      ST_SCAN_FIN: begin
        if (status.out_free) begin
          cmd.push_hold  = 1'b1;
          cmd.push_last  = 1'b1;
          cmd.hold_clear = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      emit_action <= ACT_SEND_ACK;
    end else begin
      state       <= state_next;
      emit_action <= emit_action_next;
    end
  end

endmodule

>>> src/ack_retransmit_tracker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ack_retransmit_tracker_unit
// Table of sent, unacknowledged packets with ack removal and timed resend.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream: tuser carries the command and ack flag,
//   tdata the sequence, packet handle and current time. Results leave on the
//   m_ stream: tuser is the action, tdata the sequence and handle, tlast marks
//   the final result of a request. cfg_valid with cfg_data writes the resend
//   timeout; cfg_ready is always high.
//   Steps: every request is captured, then dispatched; append and ignored
//   requests end there, drop and send-ack results go out from an emit state.
//   Ack removal searches entry by entry, then closes up behind the match;
//   the resend scan visits every entry, then a final result waits in the hold.
//   Every entry visit is a RAM read then an evaluate cycle, since the table
//   RAM has a registered read port. One request is worked at a time.
//   Reset empties the table and loads the default timeout (3500 ms); no
//   clearing pass is needed. When the receiver stalls, the output register
//   holds its result and the sequencer waits at the next result to deliver;
//   a new request is still accepted while the last result waits.
// ----------------------------------------------------------------------------
module ack_retransmit_tracker_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // sequence_req[15:0], packet_ref[23:16], now_time[55:24]
  input  logic [2:0]  s_tuser,   // cmd[1:0], is_ack[2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // out_sequence[15:0], out_ref[23:16]
  output logic [1:0]  m_tuser,   // action[1:0]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data   // resend_timeout[15:0]
);
  import art_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // timeout writes must land only while idle (the block does not enforce it); take them at once
  assign cfg_ready = 1'b1;

  art_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  art_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ack/retransmit tracking table.
// ----------------------------------------------------------------------------
// Requests go in on the s_ stream from a queue filled phase by phase. Each
// accepted request also goes through a local copy of the table, which works
// out the ack, resend and drop results it should cause. Results on the m_
// stream are checked field by field against the oldest awaited one. The
// resend timeout is rewritten between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb;
  import art_pkg::*;

  localparam int TBL_DEPTH = 16;
  localparam int HALF_PERIOD = 5;
  // longest ack removal walks the whole table
  localparam int DRAIN_CYCLES = 100;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD = 300;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // receiver stall patterns
  localparam int RX_ALWAYS = 0;
  localparam int RX_RANDOM = 1;
  localparam int RX_PATTERN = 2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        is_ack;
    logic [15:0] seq;
    logic [7:0]  handle;
    logic [31:0] now;
  } request_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] seq;
    logic [7:0]  handle;
    logic        last;
  } action_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;   // sequence_req[15:0], packet_ref[23:16], now_time[55:24]
  logic [2:0]  s_tuser = '0;   // cmd[1:0], is_ack[2]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // out_sequence[15:0], out_ref[23:16]
  logic [1:0]  m_tuser;        // action[1:0]
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;  // resend_timeout[15:0]

  // stimulus and scoreboard
  request_t queued_packets[$];
  action_t  awaited_actions[$];
  int       err_count = 0;
  int       result_count = 0;
  logic     req_fire = 1'b0;

  // local copy of the tracking table
  logic [15:0] tbl_seq[TBL_DEPTH];
  logic [7:0]  tbl_handle[TBL_DEPTH];
  logic [31:0] tbl_stamp[TBL_DEPTH];
  int          tbl_count = 0;
  logic [15:0] timeout_model = TIMEOUT_RESET;

  // sender burst state, receiver stall state
  int burst_left = 0;
  int gap_left = 0;
  int rx_mode = RX_ALWAYS;
  int hold_left = 0;
  int holds_done = 0;
  int next_hold_at = 30;
  logic [4:0] pat_cnt = '0;

  // generator view of time and of sequences likely still in the table
  logic [31:0] gen_time = 32'hC000_0000;
  logic [15:0] sent_seqs[$];

  int stall_cycles = 0;

  ack_retransmit_tracker_unit #(
    .TABLE_DEPTH(TBL_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Apply one accepted request to the local table and queue what it causes.
  function automatic void update_retransmit_table(request_t rq);
    int hit;
    int n_due;
    logic [31:0] age;
    action_t res;
    hit = -1;
    n_due = 0;
    case (rq.cmd)
      CMD_OUTGOING: begin
        if (!rq.is_ack) begin
          if (tbl_count >= TBL_DEPTH) begin
            res = '{action: ACT_DROP, seq: rq.seq, handle: rq.handle, last: 1'b1};
            awaited_actions = {awaited_actions, res};
          end else begin
            tbl_seq[tbl_count] = rq.seq;
            tbl_handle[tbl_count] = rq.handle;
            tbl_stamp[tbl_count] = rq.now;
            tbl_count++;
          end
        end
      end
      CMD_INCOMING: begin
        if (!rq.is_ack) begin
          res = '{action: ACT_SEND_ACK, seq: rq.seq, handle: rq.handle, last: 1'b1};
          awaited_actions = {awaited_actions, res};
        end else begin
          for (int i = 0; i < tbl_count; i++) begin
            if (hit < 0 && tbl_seq[i] == rq.seq) hit = i;
          end
          // close up behind the first match, keeping send order
          if (hit >= 0) begin
            for (int i = hit; i + 1 < tbl_count; i++) begin
              tbl_seq[i] = tbl_seq[i + 1];
              tbl_handle[i] = tbl_handle[i + 1];
              tbl_stamp[i] = tbl_stamp[i + 1];
            end
            tbl_count--;
          end
        end
      end
      CMD_SCAN: begin
        for (int i = 0; i < tbl_count; i++) begin
          age = rq.now - tbl_stamp[i];
          if (age > {16'd0, timeout_model}) begin
            res = '{action: ACT_RESEND, seq: tbl_seq[i], handle: tbl_handle[i], last: 1'b0};
            awaited_actions = {awaited_actions, res};
            tbl_stamp[i] = rq.now;
            n_due++;
          end
        end
        if (n_due > 0) awaited_actions[awaited_actions.size() - 1].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Monitor: check results, track config writes, predict accepted requests.
  always @(posedge clk) begin
    action_t exp_act;
    request_t rq;
    if (rst) begin
      req_fire <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        result_count++;
        if (awaited_actions.size() == 0) begin
          $error("unexpected result: action %0d out_sequence %0h out_ref %0h last %0b",
                 m_tuser, m_tdata[15:0], m_tdata[23:16], m_tlast);
          err_count++;
        end else begin
          exp_act = awaited_actions.pop_front();
          if (m_tuser !== exp_act.action) begin
            $error("action mismatch: expected %0d, actual %0d", exp_act.action, m_tuser);
            err_count++;
          end
          if (m_tdata[15:0] !== exp_act.seq) begin
            $error("out_sequence mismatch: expected %0h, actual %0h",
                   exp_act.seq, m_tdata[15:0]);
            err_count++;
          end
          if (m_tdata[23:16] !== exp_act.handle) begin
            $error("out_ref mismatch: expected %0h, actual %0h",
                   exp_act.handle, m_tdata[23:16]);
            err_count++;
          end
          if (m_tlast !== exp_act.last) begin
            $error("last mismatch: expected %0b, actual %0b", exp_act.last, m_tlast);
            err_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) timeout_model = cfg_data;
      if (s_tvalid && s_tready) begin
        rq.cmd = s_tuser[1:0];
        rq.is_ack = s_tuser[2];
        rq.seq = s_tdata[15:0];
        rq.handle = s_tdata[23:16];
        rq.now = s_tdata[55:24];
        update_retransmit_table(rq);
      end
      req_fire <= s_tvalid && s_tready;
    end
  end

  // Driver: hold the request until taken, then send in bursts with gaps.
  always @(negedge clk) begin
    request_t rq;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !req_fire) begin
      // hold: request still on offer
    end else if (gap_left > 0) begin
      s_tvalid <= 1'b0;
      gap_left--;
    end else if (queued_packets.size() > 0) begin
      rq = queued_packets.pop_front();
      s_tvalid <= 1'b1;
      s_tdata <= {rq.now, rq.handle, rq.seq};
      s_tuser <= {rq.is_ack, rq.cmd};
      if (burst_left <= 1) begin
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Receiver: a few long hold-offs, otherwise the stall pattern of the phase.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (holds_done < 3 && result_count >= next_hold_at) begin
      m_tready <= 1'b0;
      hold_left = LONG_HOLD;
      holds_done++;
      next_hold_at += 250;
    end else begin
      pat_cnt <= pat_cnt + 5'd1;
      case (rx_mode)
        RX_RANDOM:  m_tready <= ($urandom_range(0, 99) < 65);
        RX_PATTERN: m_tready <= (pat_cnt[2:0] != 3'd2) && (pat_cnt[4:3] != 2'd3);
        default:    m_tready <= 1'b1;
      endcase
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("ack_retransmit_tracker_unit test failed");
        $finish;
      end
    end
  end

  task automatic push_request(input logic [1:0] cmd, input logic is_ack,
                              input logic [15:0] seq, input logic [7:0] handle,
                              input logic [31:0] now);
    request_t rq;
    rq = '{cmd: cmd, is_ack: is_ack, seq: seq, handle: handle, now: now};
    queued_packets = {queued_packets, rq};
  endtask

  // Wait until every request is taken and every result is back, then let
  // requests that cause no result finish inside the unit.
  task automatic wait_drained();
    while (queued_packets.size() != 0 || s_tvalid || awaited_actions.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_timeout(input logic [15:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed traffic: appends, acks for sequences still in flight,
  // peer packets and scans with time moving near the timeout. The rest is
  // noise the unit ignores plus fully random requests.
  task automatic queue_traffic(input int n_items, input int unsigned tmo);
    request_t rq;
    int made;
    int pick;
    int idx;
    int unsigned advance;
    made = 0;
    while (made < n_items) begin
      pick = $urandom_range(0, 99);
      rq.cmd = CMD_OUTGOING;
      rq.is_ack = 1'b0;
      rq.seq = 16'($urandom_range(0, 65535));
      rq.handle = 8'($urandom_range(0, 255));
      rq.now = gen_time;
      if (pick < 34) begin
        // reuse a sequence now and then to get duplicates in the table
        if (sent_seqs.size() > 0 && $urandom_range(0, 9) == 0)
          rq.seq = sent_seqs[$urandom_range(0, sent_seqs.size() - 1)];
        sent_seqs = {sent_seqs, rq.seq};
        if (sent_seqs.size() > 20) void'(sent_seqs.pop_front());
        gen_time += $urandom_range(0, tmo / 8 + 1);
        made++;
      end else if (pick < 56) begin
        rq.cmd = CMD_INCOMING;
        rq.is_ack = 1'b1;
        if (sent_seqs.size() > 0 && $urandom_range(0, 9) < 8) begin
          idx = $urandom_range(0, sent_seqs.size() - 1);
          rq.seq = sent_seqs[idx];
          sent_seqs.delete(idx);
        end
        made++;
      end else if (pick < 68) begin
        rq.cmd = CMD_INCOMING;
        made++;
      end else if (pick < 88) begin
        case ($urandom_range(0, 3))
          0:       advance = tmo;
          1:       advance = tmo + 1;
          2:       advance = $urandom_range(0, 2 * tmo + 2);
          default: advance = $urandom_range(0, 3);
        endcase
        gen_time += advance;
        rq.cmd = CMD_SCAN;
        rq.is_ack = 1'($urandom_range(0, 1));
        rq.now = gen_time;
        made++;
      end else if (pick < 93) begin
        rq.is_ack = 1'b1;
      end else if (pick < 96) begin
        rq.cmd = CMD_UNUSED;
        rq.is_ack = 1'($urandom_range(0, 1));
      end else begin
        rq.cmd = 2'($urandom_range(0, 3));
        rq.is_ack = 1'($urandom_range(0, 1));
        rq.now = $urandom();
        if (rq.cmd != CMD_UNUSED && !(rq.cmd == CMD_OUTGOING && rq.is_ack)) made++;
      end
      queued_packets = {queued_packets, rq};
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, default timeout of 3500 ms.
    push_request(CMD_OUTGOING, 1'b1, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);   // outgoing ack
    push_request(CMD_UNUSED, 1'b1, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);     // unused command
    push_request(CMD_INCOMING, 1'b0, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    push_request(CMD_INCOMING, 1'b0, 16'h0000, 8'h00, 32'h0000_0000);
    push_request(CMD_OUTGOING, 1'b0, 16'h0000, 8'h00, 32'hFFFF_FF00);
    push_request(CMD_OUTGOING, 1'b0, 16'hFFFF, 8'hFF, 32'hFFFF_FF00);
    push_request(CMD_OUTGOING, 1'b0, 16'h1234, 8'h11, 32'hFFFF_FF01);
    push_request(CMD_OUTGOING, 1'b0, 16'h1234, 8'h22, 32'hFFFF_FF02);
    // age equal to the timeout: nothing due
    push_request(CMD_SCAN, 1'b0, 16'h0000, 8'h00, 32'hFFFF_FF00 + 32'd3500);
    // one ms later the first two are due, and the time wraps past zero
    push_request(CMD_SCAN, 1'b0, 16'h0000, 8'h00, 32'hFFFF_FF00 + 32'd3501);
    // ack a duplicated sequence from the middle, then one with no match
    push_request(CMD_INCOMING, 1'b1, 16'h1234, 8'h00, 32'h0000_0D00);
    push_request(CMD_INCOMING, 1'b1, 16'h5555, 8'h00, 32'h0000_0D00);
    // fill the table, overflow it once, then resend all sixteen
    for (int k = 0; k < 13; k++) begin
      push_request(CMD_OUTGOING, 1'b0, 16'(16'h0100 + k), 8'(8'h30 + k),
                   32'(32'h0000_4000 + k));
      sent_seqs = {sent_seqs, 16'(16'h0100 + k)};
    end
    push_request(CMD_OUTGOING, 1'b0, 16'hABCD, 8'h5A, 32'h0000_4100);
    push_request(CMD_SCAN, 1'b0, 16'h0000, 8'h00, 32'hC000_0000);
    wait_drained();

    // Random phases, each with its own timeout and receiver pattern.
    set_timeout(16'd1);
    rx_mode = RX_ALWAYS;
    queue_traffic(74, 1);
    wait_drained();

    set_timeout(16'hFFFF);
    rx_mode = RX_RANDOM;
    queue_traffic(74, 65535);
    wait_drained();

    set_timeout(16'd0);
    rx_mode = RX_PATTERN;
    queue_traffic(74, 0);
    wait_drained();

    begin
      int unsigned tmo_pick;
      tmo_pick = $urandom_range(1, 65535);
      set_timeout(tmo_pick[15:0]);
      rx_mode = RX_RANDOM;
      queue_traffic(74, tmo_pick);
    end
    wait_drained();

    set_timeout(16'd200);
    rx_mode = RX_PATTERN;
    queue_traffic(74, 200);
    wait_drained();

    if (awaited_actions.size() != 0) begin
      $error("%0d results never arrived", awaited_actions.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("ack_retransmit_tracker_unit test passed");
    end else begin
      $display("ack_retransmit_tracker_unit test failed");
    end
    $finish;
  end

endmodule
